// ===== hdl/tdcte_pkg.sv =====
// Shared types and constants for the converter timestamp epoch decoder.
package tdcte_pkg;

  // Fixed field widths of the beats on both channels
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OUT_CH_W = 2;
  localparam int unsigned TIME_W   = 61;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned MASK_W   = 4;

  // Coarse field: word bits 31..6, each step 5 ns, i.e. 5000 ps
  localparam int unsigned COARSE_LSB = 6;
  localparam int unsigned COARSE_W   = WORD_W - COARSE_LSB;
  localparam int unsigned COARSE_K_W = 13;
  localparam logic [COARSE_K_W-1:0] PS_PER_COARSE = 13'd5000;
  localparam int unsigned COARSE_PS_W = COARSE_W + COARSE_K_W;

  // Fine field: word bits 4..0, each step 185 ps
  localparam int unsigned FINE_W   = 5;
  localparam int unsigned FINE_K_W = 8;
  localparam logic [FINE_K_W-1:0] PS_PER_FINE = 8'd185;
  localparam int unsigned FINE_PS_W = FINE_W + FINE_K_W;

  // Edge level bit in edge mode
  localparam int unsigned EDGE_BIT = 2;

  // One epoch is 100 ms = 1e11 ps = 48828125 * 2**11 ps
  localparam int unsigned EPOCH_K_W   = 26;
  localparam logic [EPOCH_K_W-1:0] PS_EPOCH_ODD = 26'd48828125;
  localparam int unsigned EPOCH_SHIFT = 11;

  // Edge level codes
  localparam logic [LEVEL_W-1:0] LEVEL_FALL = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_RISE = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_NA   = 2'd2;

  // Reset value of the edge mode mask: channel 2 in edge mode
  localparam logic [MASK_W-1:0] MASK_RESET = 4'h4;

  // Input beat
  typedef struct packed {
    logic [NIBBLE_W-1:0] channel_nibble;
    logic [WORD_W-1:0]   timestamp_word;
  } tdcte_in_t;

  // Result beat
  typedef struct packed {
    logic [OUT_CH_W-1:0] out_channel;
    logic [TIME_W-1:0]   time_ps;
    logic [LEVEL_W-1:0]  edge_level;
  } tdcte_out_t;

  // Partial products handed from the epoch stage to the summing stage
  typedef struct packed {
    logic [OUT_CH_W-1:0]    channel;
    logic [TIME_W-1:0]      epoch_ps;
    logic [COARSE_PS_W-1:0] coarse_ps;
    logic [FINE_PS_W-1:0]   fine_ps;
    logic [LEVEL_W-1:0]     level;
  } tdcte_prod_t;

endpackage

// ===== hdl/tdcte_epoch.sv =====
// Epoch counters per channel and the product stage of the decoder.
module tdcte_epoch import tdcte_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned EPOCH_BITS   = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MASK_W-1:0] edge_mask,
  input  logic              i_valid,
  input  tdcte_in_t         i_item,
  output logic              i_stall,
  output logic              o_valid,
  output tdcte_prod_t       o_prod,
  input  logic              o_stall
);

  localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned MUL_W = EPOCH_BITS + EPOCH_K_W;

  logic [EPOCH_BITS-1:0] epoch_r [NUM_CHANNELS];
  logic                  valid_r;
  tdcte_prod_t           prod_r;

  logic                  advance;
  logic                  in_range;
  logic                  is_marker;
  logic                  is_edge;
  logic [CH_W-1:0]       ch_idx;
  logic [EPOCH_BITS-1:0] epoch_cur;
  logic [MUL_W-1:0]      epoch_mul;
  tdcte_prod_t           prod_nxt;

  // The stage moves on when its register is empty or being drained
  assign advance = !valid_r || !o_stall;
  assign i_stall = !advance;

  // Channel decode
  assign in_range  = {1'b0, i_item.channel_nibble} < (NIBBLE_W + 1)'(NUM_CHANNELS);
  assign is_marker = (i_item.timestamp_word == '0);
  assign is_edge   = (i_item.channel_nibble < NIBBLE_W'(MASK_W))
                     && edge_mask[i_item.channel_nibble[OUT_CH_W-1:0]];
  assign ch_idx    = i_item.channel_nibble[CH_W-1:0];
  assign epoch_cur = epoch_r[ch_idx];

  // Epoch, coarse and fine contributions in picoseconds
  assign epoch_mul = MUL_W'(epoch_cur) * MUL_W'(PS_EPOCH_ODD);

  always_comb begin
    prod_nxt.channel   = i_item.channel_nibble[OUT_CH_W-1:0];
    prod_nxt.epoch_ps  = TIME_W'({epoch_mul, {EPOCH_SHIFT{1'b0}}});
    prod_nxt.coarse_ps = COARSE_PS_W'(i_item.timestamp_word[WORD_W-1:COARSE_LSB])
                         * COARSE_PS_W'(PS_PER_COARSE);
    if (is_edge) begin
      prod_nxt.fine_ps = '0;
      prod_nxt.level   = i_item.timestamp_word[EDGE_BIT] ? LEVEL_RISE : LEVEL_FALL;
    end else begin
      prod_nxt.fine_ps = FINE_PS_W'(i_item.timestamp_word[FINE_W-1:0])
                         * FINE_PS_W'(PS_PER_FINE);
      prod_nxt.level   = LEVEL_NA;
    end
  end

  // Epoch counters advance on markers; markers and foreign channels give no beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        epoch_r[i] <= '0;
      end
    end else if (advance) begin
      valid_r <= i_valid && in_range && !is_marker;
      if (i_valid && in_range && is_marker) begin
        epoch_r[ch_idx] <= epoch_cur + EPOCH_BITS'(1);
      end
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r <= prod_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_prod  = prod_r;

endmodule

// ===== hdl/tdcte_sum.sv =====
// Final summing stage and result register of the decoder.
module tdcte_sum import tdcte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        i_valid,
  input  tdcte_prod_t i_prod,
  output logic        i_stall,
  output logic        out_valid,
  output tdcte_out_t  out_data,
  input  logic        out_stall
);

  logic       valid_r;
  tdcte_out_t data_r;
  tdcte_out_t data_nxt;
  logic       advance;

  assign advance = !valid_r || !out_stall;
  assign i_stall = !advance;

  // Add the three contributions, keeping the low bits of the time
  always_comb begin
    data_nxt.out_channel = i_prod.channel;
    data_nxt.time_ps     = i_prod.epoch_ps + TIME_W'(i_prod.coarse_ps)
                           + TIME_W'(i_prod.fine_ps);
    data_nxt.edge_level  = i_prod.level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/tdc_timestamp_epoch_decoder.sv =====
// Top level of the converter timestamp epoch decoder.
//
// Each input beat carries a channel nibble and a 32-bit converter word. Beats
// on channels at or above NUM_CHANNELS are dropped; a zero word advances that
// channel's wrapping epoch counter (EPOCH_BITS wide) and gives no result. Any
// other word gives one result beat with the absolute time in picoseconds:
// epoch * 1e11 + coarse * 5000, plus fine * 185 for channels in fine mode.
// Channels whose bit is set in the edge mode mask (written through cfg_data) report
// word bit 2 as the edge level instead of the fine part. The block takes one beat
// every cycle while in_stall is low; each result passes through the input
// register, the multiplier stage and the summing result register. The single
// configuration register is written through the cfg_ channel, which is always
// ready.
module tdc_timestamp_epoch_decoder import tdcte_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned EPOCH_BITS   = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tdcte_in_t         in_data,
  output logic              in_stall,
  output logic              out_valid,
  output tdcte_out_t        out_data,
  input  logic              out_stall,
  input  logic              cfg_valid,
  input  logic [MASK_W-1:0] cfg_data,
  output logic              cfg_ready
);

  logic              s1_valid_r;
  tdcte_in_t         s1_data_r;
  logic              s1_stall;
  logic [MASK_W-1:0] mask_r;
  logic              prod_valid;
  tdcte_prod_t       prod;
  logic              prod_stall;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mask_r <= cfg_data;
    end
  end

  // Input register
  assign in_stall = s1_valid_r && s1_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data;
    end
  end

  tdcte_epoch #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .EPOCH_BITS   (EPOCH_BITS)
  ) u_epoch (
    .clk       (clk),
    .rst_n     (rst_n),
    .edge_mask (mask_r),
    .i_valid   (s1_valid_r),
    .i_item    (s1_data_r),
    .i_stall   (s1_stall),
    .o_valid   (prod_valid),
    .o_prod    (prod),
    .o_stall   (prod_stall)
  );

  tdcte_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .i_valid   (prod_valid),
    .i_prod    (prod),
    .i_stall   (prod_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
